### design/url_esc_pkg.sv
// Shared types, register indexes and character helpers for the percent-escape block.
package url_esc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 16;
    localparam int unsigned MaxOut = 3;
    localparam int unsigned SlotW  = $clog2(MaxOut + 1);

    localparam logic [CountW-1:0] CapReset  = 16'd1024;
    localparam logic [CountW-1:0] CapMargin = 16'd5;

    localparam logic [ByteW-1:0] CharPercent = 8'h25;

    // Configuration register indexes
    localparam logic REG_PAIR_MODE    = 1'b0;
    localparam logic REG_OUT_CAPACITY = 1'b1;

    // One input byte's worth of output characters
    typedef struct packed {
        logic [MaxOut-1:0][ByteW-1:0] chars;
        logic [SlotW-1:0]             cnt;
        logic                         last;
        logic [CountW-1:0]            len;
    } esc_rec_t;

    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
        logic [ByteW-1:0] r;
        if (v > 4'd9) begin
            r = {4'd0, v} + 8'h37;   // 'A' - 10
        end else begin
            r = {4'd0, v} + 8'h30;   // '0'
        end
        return r;
    endfunction

    function automatic logic byte_is_safe(input logic [ByteW-1:0] b);
        logic s;
        s = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) s = 1'b1;
        if (b >= 8'h41 && b <= 8'h5A) s = 1'b1;
        if (b >= 8'h61 && b <= 8'h7A) s = 1'b1;
        if (b == 8'h24 || b == 8'h2D || b == 8'h5F || b == 8'h2E || b == 8'h21 ||
            b == 8'h2A || b == 8'h28 || b == 8'h29 || b == 8'h2C) s = 1'b1;
        return s;
    endfunction

endpackage

### design/url_esc_core.sv
// Classify one input byte, update string state and build its output record.
module url_esc_core import url_esc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CountW-1:0] cfg_wdata,
    input  logic              in_acc,
    input  logic [ByteW-1:0]  in_byte,
    input  logic              in_last,
    output logic              push_valid,
    output esc_rec_t          push_rec
);

    logic              pair_mode_reg;
    logic [CountW-1:0] capacity_reg;
    logic              pend_reg, pend_next;
    logic              run_reg, run_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              trunc_reg, trunc_next;

    logic              room;
    logic              do_esc, do_pass;
    logic [CountW:0]   sum;
    logic [CountW-1:0] sat;
    logic [SlotW-1:0]  n;

    // cnt < cap - 5 taken as signed, i.e. cnt + 5 < cap
    assign room = ({1'b0, count_reg} + {1'b0, CapMargin}) < {1'b0, capacity_reg};

    always_comb begin
        pend_next  = pend_reg;
        run_next   = run_reg;
        trunc_next = trunc_reg;
        do_esc     = 1'b0;
        do_pass    = 1'b0;
        if (!trunc_reg) begin
            if (pend_reg) begin
                do_esc    = 1'b1;
                pend_next = 1'b0;
            end else if (in_byte[ByteW-1]) begin
                if (run_reg || room) begin
                    do_esc    = 1'b1;
                    run_next  = 1'b1;
                    pend_next = pair_mode_reg;
                end else begin
                    trunc_next = 1'b1;
                end
            end else begin
                run_next = 1'b0;
                if (room) begin
                    do_pass = byte_is_safe(in_byte);
                    do_esc  = !byte_is_safe(in_byte);
                end else begin
                    trunc_next = 1'b1;
                end
            end
        end

        n   = do_esc ? SlotW'(3) : (do_pass ? SlotW'(1) : SlotW'(0));
        sum = {1'b0, count_reg} + {{(CountW + 1 - SlotW){1'b0}}, n};
        sat = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];
        count_next = sat;

        // End of string: clear everything
        if (in_last) begin
            pend_next  = 1'b0;
            run_next   = 1'b0;
            trunc_next = 1'b0;
            count_next = '0;
        end
    end

    always_comb begin
        push_rec.chars[0] = do_pass ? in_byte : CharPercent;
        push_rec.chars[1] = hex_digit(in_byte[7:4]);
        push_rec.chars[2] = hex_digit(in_byte[3:0]);
        push_rec.cnt      = n;
        push_rec.last     = in_last;
        push_rec.len      = sat;
        push_valid        = in_acc && (n != '0 || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_mode_reg <= 1'b0;
            capacity_reg  <= CapReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PAIR_MODE:    pair_mode_reg <= cfg_wdata[0];
                REG_OUT_CAPACITY: capacity_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            run_reg   <= 1'b0;
            count_reg <= '0;
            trunc_reg <= 1'b0;
        end else if (in_acc) begin
            pend_reg  <= pend_next;
            run_reg   <= run_next;
            count_reg <= count_next;
            trunc_reg <= trunc_next;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && in_last |=> count_reg == '0 && !trunc_reg && !pend_reg && !run_reg)
        else $error("string state not cleared after last byte");

    a_trunc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && trunc_reg |-> push_rec.cnt == '0)
        else $error("output produced while truncated");

    a_pend_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> run_reg)
        else $error("pair pending outside a high-byte run");

endmodule

### design/url_esc_ser.sv
// Hold one output record and hand its characters out one word at a time.
module url_esc_ser import url_esc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  esc_rec_t          push_rec,
    output logic              push_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);

    logic             busy_reg;
    esc_rec_t         rec_reg;
    logic [SlotW-1:0] idx_reg;
    logic             fin;
    logic             has_data;
    logic [ByteW-1:0] cur;

    assign has_data   = rec_reg.cnt != '0;
    assign fin        = !has_data || (idx_reg == rec_reg.cnt - SlotW'(1));
    assign push_ready = !busy_reg || (fin && m_tready);

    always_comb begin
        cur = has_data ? rec_reg.chars[idx_reg[1:0]] : '0;
        m_tvalid = busy_reg;
        m_tlast  = fin && rec_reg.last;
        m_tuser  = {fin, has_data};
        m_tdata  = {(fin && rec_reg.last) ? rec_reg.len : {CountW{1'b0}}, cur};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (push_valid && push_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            // advance within the record, or free the slot after its final word
            busy_reg <= !fin;
            idx_reg  <= idx_reg + SlotW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && push_ready) begin
            rec_reg <= push_rec;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && has_data |-> idx_reg < rec_reg.cnt)
        else $error("character index beyond record");

    a_cnt_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rec_reg.cnt == SlotW'(0) || rec_reg.cnt == SlotW'(1) ||
                     rec_reg.cnt == SlotW'(3))
        else $error("record count not 0, 1 or 3");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !has_data |-> rec_reg.last)
        else $error("end-only marker without end of string");

endmodule

### design/url_percent_escape.sv
// Top level of the streaming percent-escape encoder.
//
// Input channel s_*: one raw byte of a string per word, s_tlast on the final
// byte. Output channel m_*: one output character per word. A safe byte gives
// one word, an escaped byte gives three ('%' and two uppercase hex digits), a
// dropped byte gives none, and a final byte with nothing to send gives one
// end-only word with has_data low. m_tlast marks the final word of a string,
// which carries the total output length in the upper bits of m_tdata.
// A word accepted at one edge shows its first result in the next cycle. While
// m_tready stays high, pass-through and dropped bytes are taken at one input
// byte per cycle; an escaped byte holds off the next byte until its three
// words are out, as the single output record register gives one character per word.
// While the receiver stalls, the record register holds and s_tready stays low
// until the record's final word is taken. Reset clears the string state,
// sets pair mode off and capacity to 1024. Configuration writes through
// cfg_we/cfg_index/cfg_wdata take effect at the next edge.
module url_percent_escape import url_esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: index 0 pair_mode, index 1 out_capacity
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_in
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_length
    output logic        m_tlast,   // string_end
    output logic [1:0]  m_tuser    // [0] has_data, [1] final word of record
);

    logic     in_acc;
    logic     push_valid;
    logic     push_ready;
    esc_rec_t push_rec;

    // Take a byte whenever the record register is free or emptying this cycle
    assign s_tready = push_ready;
    assign in_acc   = s_tvalid && push_ready;

    url_esc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_acc     (in_acc),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    url_esc_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
